@@ rtl/bdpc_pkg.sv @@
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned EvWidth   = 2;
  localparam int unsigned InTdataWidth  = 40;
  localparam int unsigned OutTdataWidth = 8;

  localparam logic [CfgWidth-1:0] DebounceReset  = 16'd20;
  localparam logic [CfgWidth-1:0] LongPressReset = 16'd1000;

  typedef enum logic [EvWidth-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } cfg_reg_t;

  // One poll as it sits in the input register.
  typedef struct packed {
    logic [TimeWidth-1:0] now_ms;
    logic                 raw_level;
  } poll_t;

  // Programmed thresholds handed to the classifier.
  typedef struct packed {
    logic [CfgWidth-1:0] debounce_time;
    logic [CfgWidth-1:0] long_press_time;
  } thresholds_t;

endpackage

@@ rtl/bdpc_core.sv @@
// Debounce state and press classification for one poll per cycle while step is high.
module bdpc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  bdpc_pkg::poll_t      poll,
  input  bdpc_pkg::thresholds_t thr,
  output bdpc_pkg::press_event_t press_event
);
  import bdpc_pkg::*;

  logic                 last_raw;
  logic                 stable_level;
  logic                 long_given;
  logic [TimeWidth-1:0] change_time;
  logic [TimeWidth-1:0] press_start_time;

  logic                 last_raw_next;
  logic                 stable_level_next;
  logic                 long_given_next;
  logic [TimeWidth-1:0] change_time_next;
  logic [TimeWidth-1:0] press_start_time_next;

  logic                 raw_changed;
  logic [TimeWidth-1:0] window;
  logic [TimeWidth-1:0] held;
  logic                 settled;
  logic                 new_press;
  logic                 new_release;

  always_comb begin
    raw_changed = (poll.raw_level != last_raw);
    last_raw_next = poll.raw_level;
    change_time_next = raw_changed ? poll.now_ms : change_time;

    // A fresh raw edge leaves a window of zero, so only a zero debounce passes.
    window  = raw_changed ? '0 : (poll.now_ms - change_time);
    settled = (window >= {{(TimeWidth-CfgWidth){1'b0}}, thr.debounce_time});

    new_press   = settled && (stable_level != poll.raw_level) && poll.raw_level;
    new_release = settled && (stable_level != poll.raw_level) && !poll.raw_level;

    stable_level_next     = settled ? poll.raw_level : stable_level;
    press_start_time_next = new_press ? poll.now_ms : press_start_time;
    long_given_next       = new_press ? 1'b0 : long_given;
    press_event           = EV_NONE;

    // Press time measured from the start that holds after this poll.
    held = new_press ? '0 : (poll.now_ms - press_start_time);

    if (new_release) begin
      if (!long_given) begin
        press_event = EV_SHORT;
      end
    end else if (settled && stable_level_next && !long_given_next &&
                 (held >= {{(TimeWidth-CfgWidth){1'b0}}, thr.long_press_time})) begin
      long_given_next = 1'b1;
      press_event     = EV_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw         <= 1'b0;
      stable_level     <= 1'b0;
      long_given       <= 1'b0;
      change_time      <= '0;
      press_start_time <= '0;
    end else if (step) begin
      last_raw         <= last_raw_next;
      stable_level     <= stable_level_next;
      long_given       <= long_given_next;
      change_time      <= change_time_next;
      press_start_time <= press_start_time_next;
    end
  end

endmodule

@@ rtl/button_debounce_press_classifier.sv @@
// Top level of the button debounce and short/long press classifier.
//
// Usage: each input word on the s_axis channel is one poll of the button,
// carrying a free-running millisecond timestamp and the raw pin level. For
// every accepted word exactly one result word leaves on m_axis, holding the
// press event: none, short press released, or long press reached.
// Words flow through two registers. An accepted poll lands in the input
// register; when the result register can advance, the classifier evaluates
// it against the debounce state, updates that state, and loads the result
// register. One poll can be accepted in every clock cycle while the
// receiver keeps taking results; the classifier updates its state as each
// poll moves into the result register.
// When the receiver stalls, the result register holds its word and the
// input register keeps the next poll; s_axis_tready drops only when both
// are full and m_axis_tready is low, so no word is lost or repeated.
// Reset clears all debounce state and both pipeline registers and restores
// the thresholds to 20 ms debounce and 1000 ms long press; the pin is not
// sampled, so a button held through reset is seen as a new press.
// Thresholds are written through cfg_we/cfg_addr/cfg_wdata; the user must write them only while idle, unenforced.
module button_debounce_press_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  // Fields from bit 0: now_ms[31:0], raw_level[32], zero fill [39:33].
  input  logic [bdpc_pkg::InTdataWidth-1:0]     s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: press_event[1:0], zero fill [7:2].
  output logic [bdpc_pkg::OutTdataWidth-1:0]    m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_we,
  input  logic                                  cfg_addr,
  input  logic [bdpc_pkg::CfgWidth-1:0]         cfg_wdata
);
  import bdpc_pkg::*;

  thresholds_t  thr;
  poll_t        in_word;
  logic         in_valid;
  press_event_t out_event;
  logic         out_valid;
  press_event_t core_event;
  logic         advance;

  // The result register frees up when empty or when its word is taken.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.debounce_time   <= DebounceReset;
      thr.long_press_time <= LongPressReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE:   thr.debounce_time   <= cfg_wdata;
        REG_LONG_PRESS: thr.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word.now_ms    <= s_axis_tdata[TimeWidth-1:0];
      in_word.raw_level <= s_axis_tdata[TimeWidth];
    end
  end

  bdpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_valid && advance),
    .poll        (in_word),
    .thr         (thr),
    .press_event (core_event)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_event <= core_event;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutTdataWidth-EvWidth){1'b0}}, out_event};

endmodule

@@ verif/tb_button_debounce_press_classifier.sv @@
// Self-checking testbench for the button debounce and short/long press classifier.
module tb_button_debounce_press_classifier;
  import bdpc_pkg::*;

  // A receiver hold-off this long fills both pipeline registers and stalls the input side.
  localparam int unsigned HoldCycles = 200;
  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned StuckLimit = 4000;
  // Each accepted poll passes only the input and result registers, so a short settle is enough.
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    logic [TimeWidth-1:0] stamp;
    logic                 level;
  } poll_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Fields from bit 0: now_ms[31:0], raw_level[32], zero fill [39:33].
  logic [InTdataWidth-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // Fields from bit 0: press_event[1:0], zero fill [7:2].
  logic [OutTdataWidth-1:0] m_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic                     cfg_we = 1'b0;
  logic                     cfg_addr = REG_DEBOUNCE;
  logic [CfgWidth-1:0]      cfg_wdata = '0;

  button_debounce_press_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Polls waiting to be offered, and press events predicted for accepted polls.
  poll_word_t   poll_q[$];
  press_event_t event_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned pushed_cnt = 0;

  // Percent of cycles in which the sender or the receiver sits idle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // The stimulus bumps the token; the receiver notices it and holds off on its own count.
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Predictor state: the thresholds as the block holds them and the debounce history.
  logic [CfgWidth-1:0]  deb_ms;
  logic [CfgWidth-1:0]  long_ms;
  logic                 last_raw;
  logic                 stable_lvl;
  logic                 long_done;
  logic [TimeWidth-1:0] change_t;
  logic [TimeWidth-1:0] press_t;

  // Thresholds the stimulus has programmed, used only to shape the press timing.
  int unsigned cur_deb = DebounceReset;
  int unsigned cur_long = LongPressReset;
  logic [TimeWidth-1:0] t_cur = '0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Steps the debounce state with one poll and returns the event it causes.
  function automatic press_event_t classify_poll(input logic [TimeWidth-1:0] now,
                                                 input logic raw);
    press_event_t ev;
    logic         released;
    ev = EV_NONE;
    released = 1'b0;
    // Any change of the raw level restarts the debounce window.
    if (raw != last_raw) begin
      last_raw = raw;
      change_t = now;
    end
    if (TimeWidth'(now - change_t) >= {16'd0, deb_ms}) begin
      if (stable_lvl != raw) begin
        stable_lvl = raw;
        if (raw) begin
          press_t = now;
          long_done = 1'b0;
        end else if (!long_done) begin
          ev = EV_SHORT;
          released = 1'b1;
        end
      end
      // A press held long enough gives one long event; with a zero long time
      // that happens on the very poll that accepts the press.
      if (!released && stable_lvl && !long_done &&
          TimeWidth'(now - press_t) >= {16'd0, long_ms}) begin
        long_done = 1'b1;
        ev = EV_LONG;
      end
    end
    return ev;
  endfunction

  // Sender: a new word may go on the bus once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        poll_word_t w;
        w = poll_q.pop_front();
        s_axis_tdata  <= {7'd0, w.level, w.stamp};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: tracks register writes, predicts each accepted poll and checks each result word.
  always @(posedge clk) begin
    if (rst) begin
      deb_ms     = DebounceReset;
      long_ms    = LongPressReset;
      last_raw   = 1'b0;
      stable_lvl = 1'b0;
      long_done  = 1'b0;
      change_t   = '0;
      press_t    = '0;
      event_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_DEBOUNCE) deb_ms = cfg_wdata;
        else long_ms = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready)
        event_q.push_back(classify_poll(s_axis_tdata[31:0], s_axis_tdata[32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_q.size() == 0) begin
          report_mismatch($sformatf("result word 0x%02h with nothing expected", m_axis_tdata));
        end else begin
          press_event_t want;
          want = event_q.pop_front();
          if (m_axis_tdata[1:0] !== want)
            report_mismatch($sformatf("press_event %0d, expected %0d (%s)",
                                      m_axis_tdata[1:0], want, want.name()));
          if (m_axis_tdata[7:2] !== 6'd0)
            report_mismatch($sformatf("fill bits 0x%02h not zero", m_axis_tdata[7:2]));
        end
      end
    end
  end

  // Watchdog: a stretch with no word moving on either side means the block hung.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StuckLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_poll(input logic [TimeWidth-1:0] stamp, input logic level);
    poll_word_t w;
    w.stamp = stamp;
    w.level = level;
    poll_q.push_back(w);
    pushed_cnt++;
  endtask

  // Waits on the falling edge, when all rising-edge updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (poll_q.size() != 0 || s_axis_tvalid || event_q.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgWidth-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_thresholds(input int unsigned deb, input int unsigned lng);
    wait_drained();
    write_reg(REG_DEBOUNCE, CfgWidth'(deb));
    write_reg(REG_LONG_PRESS, CfgWidth'(lng));
    cur_deb  = deb;
    cur_long = lng;
  endtask

  // A few bounces shorter than the debounce time, then the settled level.
  task automatic bounce_to(input logic level);
    int unsigned n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      t_cur += $urandom_range(0, cur_deb / 3 + 1);
      push_poll(t_cur, 1'($urandom_range(1)));
    end
    t_cur += $urandom_range(0, cur_deb / 3 + 1);
    push_poll(t_cur, level);
  endtask

  // Holds a level for roughly the given span, spread over a handful of polls.
  task automatic hold_level(input logic level, input int unsigned span, input int unsigned polls);
    repeat (polls) begin
      t_cur += $urandom_range(1, 2 * span / polls + 1);
      push_poll(t_cur, level);
    end
  endtask

  // One press: bounce in, hold short or past the long time, bounce out, rest released.
  task automatic press_episode();
    int unsigned span;
    if ($urandom_range(1)) span = cur_long + $urandom_range(0, cur_long / 2 + 5);
    else span = $urandom_range(0, cur_long);
    bounce_to(1'b1);
    hold_level(1'b1, span + cur_deb, $urandom_range(1, 10));
    bounce_to(1'b0);
    hold_level(1'b0, cur_deb + $urandom_range(0, cur_deb + 20), $urandom_range(1, 4));
  endtask

  // Mostly clean press sequences with random timing; the rest is noise and odd jumps in time.
  task automatic random_polls(input int unsigned n);
    int unsigned start;
    int unsigned r;
    start = pushed_cnt;
    while (pushed_cnt - start < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        t_cur = $urandom;
        push_poll(t_cur, 1'($urandom_range(1)));
      end else if (r < 8) begin
        // Timestamps running backwards wrap in the window arithmetic.
        t_cur -= $urandom_range(1, cur_deb + cur_long + 1);
        push_poll(t_cur, 1'($urandom_range(1)));
      end else if (r < 14) begin
        t_cur += $urandom_range(0, cur_deb + cur_long + 1);
        push_poll(t_cur, 1'($urandom_range(1)));
      end else begin
        press_episode();
      end
    end
  endtask

  initial begin
    send_idle_pct = 20;
    recv_idle_pct = 50;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset thresholds, 20 ms debounce and 1000 ms long press. The first poll has the
    // button already down, which must count as a fresh press once debounced.
    push_poll(32'd0, 1'b1);
    push_poll(32'd19, 1'b1);
    push_poll(32'd20, 1'b1);
    push_poll(32'd500, 1'b1);
    push_poll(32'd1019, 1'b1);
    push_poll(32'd1020, 1'b1);
    push_poll(32'd1500, 1'b1);
    // Release after the long event stays silent.
    push_poll(32'd1510, 1'b0);
    push_poll(32'd1529, 1'b0);
    push_poll(32'd1530, 1'b0);
    // A short press with a bounce in the middle of the release.
    push_poll(32'd2000, 1'b1);
    push_poll(32'd2036, 1'b1);
    push_poll(32'd2100, 1'b0);
    push_poll(32'd2105, 1'b1);
    push_poll(32'd2110, 1'b0);
    push_poll(32'd2130, 1'b0);
    // Press across the wrap of the millisecond counter.
    push_poll(32'hFFFF_FFF0, 1'b1);
    push_poll(32'h0000_0004, 1'b1);
    push_poll(32'h0000_0100, 1'b0);
    push_poll(32'h0000_0114, 1'b0);
    // A timestamp that jumps backwards looks like a huge elapsed time.
    push_poll(32'h0000_0200, 1'b1);
    push_poll(32'h0000_01F0, 1'b1);
    push_poll(32'hFFFF_FFFF, 1'b0);
    push_poll(32'h0000_0000, 1'b0);
    t_cur = $urandom;
    random_polls(60);

    // Both thresholds at zero: a press gives its long event on the accepting poll.
    set_thresholds(0, 0);
    // Fill the queue first, then hold the receiver off so the block backs up.
    push_poll(t_cur + 1, 1'b1);
    push_poll(t_cur + 2, 1'b1);
    push_poll(t_cur + 3, 1'b0);
    t_cur += 3;
    random_polls(120);
    hold_token++;

    send_idle_pct = 50;
    recv_idle_pct = 20;
    set_thresholds(3, 40);
    random_polls(160);

    set_thresholds(65535, 65535);
    random_polls(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Zero debounce with a nonzero long time: an immediate release is a short press.
    set_thresholds(0, 5);
    push_poll(t_cur + 1, 1'b1);
    push_poll(t_cur + 2, 1'b0);
    t_cur += 2;
    random_polls(100);

    set_thresholds($urandom_range(1, 200), $urandom_range(1, 3000));
    random_polls(150);

    set_thresholds(DebounceReset, LongPressReset);
    random_polls(100);

    wait_drained();
    if (mismatch_cnt == 0 && event_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
